### rtl/spectrum_polyline_vertex_reducer_macros.svh
// Assertion macros used by the vertex reducer datapath.
`ifndef SPECTRUM_POLYLINE_VERTEX_REDUCER_MACROS_SVH
`define SPECTRUM_POLYLINE_VERTEX_REDUCER_MACROS_SVH

`ifndef SYNTH
// Check a property while out of reset
`define SVR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("svr check failed");
// Check a property at every edge, reset included
`define SVR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("svr check failed");
`else
`define SVR_ASSERT(lbl, clk, rstn, prop)
`define SVR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/svr_pkg.sv
// Types, constants and helpers shared by the vertex reducer modules.
`default_nettype none

package svr_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int SMP_W       = 8;
    localparam int COORD_W     = 15;
    localparam int PC_W        = 11;
    localparam int PIX_W       = 10;
    localparam int BRD_W       = 8;
    localparam int SPAN_W      = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int NUM_W       = IDX_W + SPAN_W;
    localparam int PY_W        = SMP_W + SPAN_W;
    localparam int DCNT_W      = $clog2(NUM_W);
    localparam int SUBPIX_SH   = 4;      // pixels to 1/16 pixel
    localparam int Y_SCALE_SH  = 8;      // divide by 256
    localparam int EDGE_OFS    = 16;     // fixed offset past the border
    localparam int SPAN_TRIM   = 32;     // fixed trim of the usable span

    localparam logic [IDX_W-1:0]   IDX_MAX   = IDX_W'(MAX_POINTS - 1);
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT   = 2'd0,
        REG_WIDGET_WIDTH  = 2'd1,
        REG_WIDGET_HEIGHT = 2'd2,
        REG_BORDER_WIDTH  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_svr_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_step;
        logic commit;
    } t_svr_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_svr_sts;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               item_last;
        logic               strip_end;
    } t_vertex;

    // Usable span in 1/16 pixel: pixels*16 - 2*border - 32, floored at zero
    function automatic logic [SPAN_W-1:0] usable_span(
        input logic [PIX_W-1:0] pix,
        input logic [BRD_W-1:0] brd
    );
        logic [SPAN_W-1:0] full;
        logic [SPAN_W-1:0] trim;
        full = {pix, {SUBPIX_SH{1'b0}}};
        trim = SPAN_W'({brd, 1'b0}) + SPAN_W'(SPAN_TRIM);
        return (full > trim) ? (full - trim) : '0;
    endfunction

endpackage

`default_nettype wire

### rtl/svr_ctrl.sv
// Sequencer for the vertex reducer: accept, prepare, divide, emit.
`default_nettype none

module svr_ctrl import svr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_svr_sts i_sts,
    output t_svr_cmd      o_cmd
);

    t_svr_state r_state;
    t_svr_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands and input stall
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            S_PREP: o_cmd.prep     = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_DONE: o_cmd.commit   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/svr_datapath.sv
// Datapath: configuration, scaling, serial divider, run reduction, result buffer.
`default_nettype none

`include "spectrum_polyline_vertex_reducer_macros.svh"

module svr_datapath import svr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_svr_cmd              i_cmd,
    output t_svr_sts                   o_sts,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [SMP_W-1:0]      i_sample,
    input  wire logic                  i_frame_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COORD_W-1:0]         o_vertex_x,
    output logic [COORD_W-1:0]         o_vertex_y,
    output logic                       o_item_last,
    output logic                       o_strip_end
);

    // Configuration
    logic [PC_W-1:0]  r_point_count;
    logic [PIX_W-1:0] r_widget_width;
    logic [PIX_W-1:0] r_widget_height;
    logic [BRD_W-1:0] r_border_width;

    // Frame state
    logic [IDX_W-1:0]   r_index;
    logic [COORD_W-1:0] r_prev_x;
    logic [COORD_W-1:0] r_prev_y;
    logic               r_flat;

    // Current word
    logic [SMP_W-1:0] r_sample;
    logic             r_last;

    // Divider
    logic [PC_W-1:0]   r_div;
    logic [PC_W-1:0]   r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DCNT_W-1:0] r_dcnt;
    logic [PY_W-1:0]   r_prod_y;

    // Result buffer
    t_vertex    r_q0;
    t_vertex    r_q1;
    logic [1:0] r_out_cnt;

    logic [PC_W:0]      shifted;
    logic [PC_W:0]      trial;
    logic [NUM_W:0]     x_sum;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic               same_y;
    t_vertex            n_first;
    t_vertex            n_second;
    logic [1:0]         n_count;
    logic               pop;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count   <= PC_W'(2);
            r_widget_width  <= '0;
            r_widget_height <= '0;
            r_border_width  <= BRD_W'(32);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_POINT_COUNT:   r_point_count   <= i_cfg_data;
                REG_WIDGET_WIDTH:  r_widget_width  <= i_cfg_data[PIX_W-1:0];
                REG_WIDGET_HEIGHT: r_widget_height <= i_cfg_data[PIX_W-1:0];
                REG_BORDER_WIDTH:  r_border_width  <= i_cfg_data[BRD_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
            r_last   <= i_frame_last;
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign trial   = shifted - {1'b0, r_div};

    // Prepare products and run the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_quo    <= NUM_W'(r_index)
                      * NUM_W'(usable_span(r_widget_width, r_border_width));
            r_prod_y <= PY_W'(r_sample)
                      * PY_W'(usable_span(r_widget_height, r_border_width));
            r_div    <= (r_point_count < PC_W'(2)) ? PC_W'(1) : (r_point_count - PC_W'(1));
            r_rem    <= '0;
            r_dcnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DCNT_W'(1);
            if (!trial[PC_W]) begin
                r_rem <= trial[PC_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[PC_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.div_last = (r_dcnt == DCNT_W'(NUM_W - 1));
    assign o_sts.out_free = (r_out_cnt == 2'd0);

    // Offset both coordinates and saturate X
    assign x_sum = {1'b0, r_quo} + (NUM_W+1)'(r_border_width) + (NUM_W+1)'(EDGE_OFS);
    assign cur_x = (x_sum > (NUM_W+1)'(COORD_MAX)) ? COORD_MAX : x_sum[COORD_W-1:0];
    assign cur_y = COORD_W'(r_prod_y[PY_W-1:Y_SCALE_SH]) + COORD_W'(r_border_width)
                 + COORD_W'(EDGE_OFS);

    assign same_y = (r_index != '0) && (cur_y == r_prev_y);

    // Pick the words this sample emits
    always_comb begin
        n_first  = '{x: cur_x, y: cur_y, item_last: 1'b1, strip_end: r_last};
        n_second = n_first;
        n_count  = 2'd0;
        if (!same_y && r_flat) begin
            n_first  = '{x: r_prev_x, y: r_prev_y, item_last: 1'b0, strip_end: 1'b0};
            n_count  = 2'd2;
        end else if (!same_y || r_last) begin
            n_count  = 2'd1;
        end
    end

    // Update frame state on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index  <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_flat   <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_index  <= '0;
                r_prev_x <= '0;
                r_prev_y <= '0;
                r_flat   <= 1'b0;
            end else begin
                r_prev_x <= cur_x;
                r_prev_y <= cur_y;
                r_flat   <= same_y;
                if (r_index < IDX_MAX) r_index <= r_index + IDX_W'(1);
            end
        end
    end

    // Result buffer: load up to two words, drain from the head
    assign pop = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (i_cmd.commit) begin
            r_out_cnt <= n_count;
        end else if (pop) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_q0 <= n_first;
            r_q1 <= n_second;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_out_valid = (r_out_cnt != 2'd0);
    assign o_vertex_x  = r_q0.x;
    assign o_vertex_y  = r_q0.y;
    assign o_item_last = r_q0.item_last;
    assign o_strip_end = r_q0.strip_end;

    `SVR_ASSERT_ALWAYS(a_out_cnt_reset, i_clk, !i_rst_n |=> (r_out_cnt == 2'd0))
    `SVR_ASSERT(a_out_cnt_range, i_clk, i_rst_n, r_out_cnt != 2'd3)
    `SVR_ASSERT(a_rem_below_div, i_clk, i_rst_n, i_cmd.div_step |-> (r_rem < r_div))
    `SVR_ASSERT(a_commit_empty, i_clk, i_rst_n, i_cmd.commit |-> (r_out_cnt == 2'd0))
    `SVR_ASSERT(a_pair_ends_last, i_clk, i_rst_n, (o_out_valid && !o_item_last) |-> (r_out_cnt == 2'd2))

endmodule

`default_nettype wire

### rtl/spectrum_polyline_vertex_reducer.sv
// Spectrum polyline vertex reducer, top level.
// A sample is prepared, then run through the 24-step serial divider for X, and its
// words are committed once the output is empty; the next sample waits for that commit.
// A new sample is taken while up to two finished words wait on the output.
// Reset (synchronous, active low) restores the register defaults and clears the
// sample index, the previous vertex, the flat-run flag and the output word count.
`default_nettype none

module spectrum_polyline_vertex_reducer import svr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [SMP_W-1:0]      i_sample,
    input  wire logic                  i_frame_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COORD_W-1:0]         o_vertex_x,
    output logic [COORD_W-1:0]         o_vertex_y,
    output logic                       o_item_last,
    output logic                       o_strip_end
);

    t_svr_cmd cmd;
    t_svr_sts sts;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    svr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    svr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_sample),
        .i_frame_last (i_frame_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_vertex_x   (o_vertex_x),
        .o_vertex_y   (o_vertex_y),
        .o_item_last  (o_item_last),
        .o_strip_end  (o_strip_end)
    );

endmodule

`default_nettype wire
